// ===== sv/cdfpr_pkg.sv =====
package cdfpr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 7;
    localparam int PORT_IDX_W  = 6;
    localparam int RADIUS_W    = 24;
    localparam int PROB_W      = 17;
    localparam int PROD_W      = RADIUS_W + PROB_W;
    localparam int DIV_BITS    = 2;
    localparam int DIV_CYCLES  = RADIUS_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(65536);

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_FETCH,
        ST_TAKE_HI,
        ST_TAKE_LO,
        ST_MULTIPLY,
        ST_DIVIDE,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

// ===== sv/cdf_percentile_radius_lookup.sv =====
// Inverse-CDF radius lookup over a table of up to 64 (radius, probability) points held
// in two synchronous memories, each with one write port and one registered read port.
// A load item writes one point and returns a result (radius 0, status ok). A query runs
// a lower-bound binary search, each probe a memory read and then a compare, at most
// seven probes, then reads the two neighboring points, multiplies the radius span by
// the probability offset and divides by the probability span in a restoring divider
// that retires two quotient bits per cycle. Clamped, first-point or equal-probability
// queries skip the divider, and out-of-range or empty-table queries skip the search.
// The block works on one item at a time; item_stall is high while an item is in flight,
// and the result register lets the next item in while an earlier result still waits.
// entry_count may be written at any time the block is idle; cfg_ready is always high.
module cdf_percentile_radius_lookup
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdfpr_pkg::CFG_W-1:0]         entry_count,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [cdfpr_pkg::PORT_IDX_W-1:0]    entry_index,
    input  logic [cdfpr_pkg::RADIUS_W-1:0]      entry_radius,
    input  logic [cdfpr_pkg::PROB_W-1:0]        entry_probability,
    input  logic [cdfpr_pkg::PROB_W-1:0]        percentile,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [cdfpr_pkg::RADIUS_W-1:0]      radius,
    output logic [1:0]                          status
);

    cdfpr_pkg::state_t state_reg, state_next;

    logic [cdfpr_pkg::CFG_W-1:0]      count_reg;

    logic [cdfpr_pkg::RADIUS_W-1:0]   radius_mem [cdfpr_pkg::TABLE_DEPTH];
    logic [cdfpr_pkg::PROB_W-1:0]     prob_mem   [cdfpr_pkg::TABLE_DEPTH];
    logic [cdfpr_pkg::RADIUS_W-1:0]   rd_radius_reg;
    logic [cdfpr_pkg::PROB_W-1:0]     rd_prob_reg;
    logic [cdfpr_pkg::IDX_W-1:0]      rd_addr;
    logic                             wr_en;

    logic [cdfpr_pkg::PROB_W-1:0]     pct_reg, pct_next;
    logic [cdfpr_pkg::CNT_W-1:0]      n_reg, n_next;
    logic [cdfpr_pkg::CNT_W-1:0]      lo_reg, lo_next;
    logic [cdfpr_pkg::CNT_W-1:0]      hi_reg, hi_next;
    logic [cdfpr_pkg::CNT_W-1:0]      mid_reg, mid_next;
    logic [cdfpr_pkg::CNT_W:0]        mid_sum;
    logic [cdfpr_pkg::CNT_W-1:0]      last_idx;
    logic [cdfpr_pkg::CNT_W-1:0]      below_idx;
    logic                             take_hi_only;

    logic [cdfpr_pkg::RADIUS_W-1:0]   r_hi_reg, r_hi_next;
    logic [cdfpr_pkg::PROB_W-1:0]     p_hi_reg, p_hi_next;
    logic [cdfpr_pkg::RADIUS_W-1:0]   r_lo_reg, r_lo_next;
    logic [cdfpr_pkg::RADIUS_W-1:0]   span_reg, span_next;
    logic [cdfpr_pkg::PROB_W-1:0]     num_reg, num_next;
    logic [cdfpr_pkg::PROB_W-1:0]     den_reg, den_next;
    logic                             desc_reg, desc_next;
    logic [cdfpr_pkg::PROB_W-1:0]     rem_reg, rem_next;
    logic [cdfpr_pkg::RADIUS_W-1:0]   quo_reg, quo_next;
    logic [cdfpr_pkg::DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    logic [cdfpr_pkg::RADIUS_W-1:0]   res_radius_reg, res_radius_next;
    cdfpr_pkg::status_t               res_status_reg, res_status_next;

    logic                             out_valid_reg;
    logic [cdfpr_pkg::RADIUS_W-1:0]   out_radius_reg;
    cdfpr_pkg::status_t               out_status_reg;
    logic                             push;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != cdfpr_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign radius       = out_radius_reg;
    assign status       = out_status_reg;

    assign mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign last_idx     = n_reg - cdfpr_pkg::CNT_W'(1);
    assign below_idx    = lo_reg - cdfpr_pkg::CNT_W'(1);
    // clamp past the last point, or the first point itself: no interpolation
    assign take_hi_only = (lo_reg >= n_reg) || (lo_reg == '0);

    // table memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            radius_mem[cdfpr_pkg::IDX_W'(entry_index)] <= entry_radius;
            prob_mem[cdfpr_pkg::IDX_W'(entry_index)]   <= entry_probability;
        end
        rd_radius_reg <= radius_mem[rd_addr];
        rd_prob_reg   <= prob_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdfpr_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= entry_count;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pct_reg        <= pct_next;
        n_reg          <= n_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        r_hi_reg       <= r_hi_next;
        p_hi_reg       <= p_hi_next;
        r_lo_reg       <= r_lo_next;
        span_reg       <= span_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        desc_reg       <= desc_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        res_radius_reg <= res_radius_next;
        res_status_reg <= res_status_next;
        if (push)
        begin
            out_radius_reg <= res_radius_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        logic [cdfpr_pkg::PROD_W-1:0]   prod;
        logic [cdfpr_pkg::PROB_W:0]     trial;
        logic [cdfpr_pkg::PROB_W-1:0]   rem_w;
        logic [cdfpr_pkg::RADIUS_W-1:0] quo_w;
        logic [cdfpr_pkg::RADIUS_W-1:0] q_final;

        state_next      = state_reg;
        pct_next        = pct_reg;
        n_next          = n_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        r_hi_next       = r_hi_reg;
        p_hi_next       = p_hi_reg;
        r_lo_next       = r_lo_reg;
        span_next       = span_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        desc_next       = desc_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        res_radius_next = res_radius_reg;
        res_status_next = res_status_reg;
        rd_addr         = mid_reg[cdfpr_pkg::IDX_W-1:0];
        wr_en           = 1'b0;
        push            = 1'b0;
        prod            = '0;
        trial           = '0;
        rem_w           = rem_reg;
        quo_w           = quo_reg;
        q_final         = '0;

        case (state_reg)
            cdfpr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    res_radius_next = '0;
                    res_status_next = cdfpr_pkg::STATUS_OK;
                    pct_next        = percentile;
                    lo_next         = '0;
                    if (int'(count_reg) > cdfpr_pkg::TABLE_DEPTH)
                    begin
                        n_next = cdfpr_pkg::CNT_W'(cdfpr_pkg::TABLE_DEPTH);
                    end
                    else
                    begin
                        n_next = cdfpr_pkg::CNT_W'(count_reg);
                    end
                    hi_next    = n_next;
                    state_next = cdfpr_pkg::ST_DONE;
                    if (command == cdfpr_pkg::CMD_LOAD)
                    begin
                        wr_en = (int'(entry_index) < cdfpr_pkg::TABLE_DEPTH);
                    end
                    else if (percentile > cdfpr_pkg::PROB_ONE)
                    begin
                        res_status_next = cdfpr_pkg::STATUS_RANGE;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = cdfpr_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = cdfpr_pkg::ST_SEARCH;
                    end
                end
            end

            cdfpr_pkg::ST_SEARCH:
            begin
                mid_next = mid_sum[cdfpr_pkg::CNT_W:1];
                rd_addr  = mid_next[cdfpr_pkg::IDX_W-1:0];
                if (lo_reg < hi_reg)
                begin
                    state_next = cdfpr_pkg::ST_COMPARE;
                end
                else
                begin
                    state_next = cdfpr_pkg::ST_FETCH;
                end
            end

            cdfpr_pkg::ST_COMPARE:
            begin
                if (rd_prob_reg < pct_reg)
                begin
                    lo_next = mid_reg + cdfpr_pkg::CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = cdfpr_pkg::ST_SEARCH;
            end

            cdfpr_pkg::ST_FETCH:
            begin
                if (lo_reg >= n_reg)
                begin
                    rd_addr = last_idx[cdfpr_pkg::IDX_W-1:0];
                end
                else
                begin
                    rd_addr = lo_reg[cdfpr_pkg::IDX_W-1:0];
                end
                state_next = cdfpr_pkg::ST_TAKE_HI;
            end

            cdfpr_pkg::ST_TAKE_HI:
            begin
                r_hi_next = rd_radius_reg;
                p_hi_next = rd_prob_reg;
                rd_addr   = below_idx[cdfpr_pkg::IDX_W-1:0];
                if (take_hi_only)
                begin
                    res_radius_next = rd_radius_reg;
                    state_next      = cdfpr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cdfpr_pkg::ST_TAKE_LO;
                end
            end

            cdfpr_pkg::ST_TAKE_LO:
            begin
                r_lo_next = rd_radius_reg;
                desc_next = (r_hi_reg < rd_radius_reg);
                if (r_hi_reg < rd_radius_reg)
                begin
                    span_next = rd_radius_reg - r_hi_reg;
                end
                else
                begin
                    span_next = r_hi_reg - rd_radius_reg;
                end
                num_next = pct_reg - rd_prob_reg;
                den_next = p_hi_reg - rd_prob_reg;
                // flat or falling probability step takes the found point's radius
                if (p_hi_reg <= rd_prob_reg)
                begin
                    res_radius_next = r_hi_reg;
                    state_next      = cdfpr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cdfpr_pkg::ST_MULTIPLY;
                end
            end

            cdfpr_pkg::ST_MULTIPLY:
            begin
                prod = cdfpr_pkg::PROD_W'(span_reg) * cdfpr_pkg::PROD_W'(num_reg);
                // num <= den keeps the upper part below den, so 24 quotient bits suffice
                rem_next     = prod[cdfpr_pkg::PROD_W-1:cdfpr_pkg::RADIUS_W];
                quo_next     = prod[cdfpr_pkg::RADIUS_W-1:0];
                div_cnt_next = '0;
                state_next   = cdfpr_pkg::ST_DIVIDE;
            end

            cdfpr_pkg::ST_DIVIDE:
            begin
                for (int k = 0; k < cdfpr_pkg::DIV_BITS; k++)
                begin
                    trial = {rem_w, quo_w[cdfpr_pkg::RADIUS_W-1]};
                    quo_w = {quo_w[cdfpr_pkg::RADIUS_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_w    = cdfpr_pkg::PROB_W'(trial - {1'b0, den_reg});
                        quo_w[0] = 1'b1;
                    end
                    else
                    begin
                        rem_w = trial[cdfpr_pkg::PROB_W-1:0];
                    end
                end
                rem_next     = rem_w;
                quo_next     = quo_w;
                div_cnt_next = div_cnt_reg + cdfpr_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == cdfpr_pkg::DIV_CNT_W'(cdfpr_pkg::DIV_CYCLES - 1))
                begin
                    state_next = cdfpr_pkg::ST_FINISH;
                end
            end

            cdfpr_pkg::ST_FINISH:
            begin
                // falling radius: floor of the result means rounding the step up
                q_final = quo_reg + cdfpr_pkg::RADIUS_W'(desc_reg && (rem_reg != '0));
                if (desc_reg)
                begin
                    res_radius_next = r_lo_reg - q_final;
                end
                else
                begin
                    res_radius_next = r_lo_reg + q_final;
                end
                state_next = cdfpr_pkg::ST_DONE;
            end

            cdfpr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    push       = 1'b1;
                    state_next = cdfpr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cdfpr_pkg::ST_IDLE;
            end
        endcase
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cdfpr_pkg::ST_DONE))
        else $error("result raised outside the done state");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdfpr_pkg::ST_DIVIDE) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdfpr_pkg::ST_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= n_reg))
        else $error("search bounds out of order");

    a_error_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != cdfpr_pkg::STATUS_OK) |-> (out_radius_reg == '0))
        else $error("error result carries nonzero radius");

endmodule
